// ===== rtl/first_fit_page_allocator_assert.svh =====
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH

// Clocked property, off during reset.
`define FFPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled channel keeps valid and payload.
`define FFPA_ASSERT_HOLD(lbl, vld, rdy, pay, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(pay))) else $error(msg);

`endif

// ===== rtl/ffpa_pkg.sv =====
package ffpa_pkg;

    localparam int unsigned PAGE_BYTES = 4096;
    localparam int unsigned NUM_PAGES  = 1024;
    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int unsigned IDX_W      = $clog2(NUM_PAGES);
    localparam int unsigned PG_W       = $clog2(NUM_PAGES + 1);
    localparam int unsigned CNT_W      = 11;
    localparam int unsigned RUN_MAX    = 2047;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned WIDE_W     = ADDR_W + 1;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOSPACE = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_SMALL   = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;
    localparam logic [2:0] ST_BLOCK   = 3'd5;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT = 2'd3;

    localparam logic [ADDR_W-1:0] HEAP_START_RST  = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST  = 32'h8200_0000;
    localparam logic [ADDR_W-1:0] HEAP_END_RST    = 32'hA000_0000;
    localparam logic [15:0]       SMALL_LIMIT_RST = 16'd2048;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] request_bytes;
        logic [ADDR_W-1:0] release_address;
    } req_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] address;
        logic [CNT_W-1:0]  pages_changed;
    } rsp_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] heap_start;
        logic [ADDR_W-1:0] heap_limit;
        logic [ADDR_W-1:0] heap_end;
        logic [15:0]       small_limit;
    } cfg_regs_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_data;
    } bm_req_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

// ===== rtl/first_fit_page_allocator.sv =====
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    cmd, request_bytes, release_address
// rsp      out  rsp_valid/rsp_ready    status, address, pages_changed
// cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item at a time. Allocate: setup states work out the region and check the request,
// then a first-fit scan of the bitmap (up to the region size) and a mark of each page.
// Free: range and page checks, then each page of the run is cleared in turn.
// After reset the bitmap sweep clears all NUM_PAGES (1024) pages; req_ready stays low meanwhile.
// A result waiting on rsp_ready holds off only the next result, not the next item.
module first_fit_page_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  ffpa_pkg::req_item_t                req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output ffpa_pkg::rsp_item_t                rsp,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffpa_pkg::ADDR_W-1:0]        cfg_data
);
    import ffpa_pkg::*;

    cfg_regs_t         cfg_reg;
    bm_req_t           bm_req;
    logic              bm_rd_data;
    logic              bm_busy;
    alu_op_t           alu_op;
    logic [WIDE_W-1:0] alu_a;
    logic [WIDE_W-1:0] alu_b;
    logic [WIDE_W-1:0] alu_y;
    logic              alu_borrow;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heap_start  <= HEAP_START_RST;
            cfg_reg.heap_limit  <= HEAP_LIMIT_RST;
            cfg_reg.heap_end    <= HEAP_END_RST;
            cfg_reg.small_limit <= SMALL_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HEAP_START:  cfg_reg.heap_start  <= cfg_data;
                CFG_HEAP_LIMIT:  cfg_reg.heap_limit  <= cfg_data;
                CFG_HEAP_END:    cfg_reg.heap_end    <= cfg_data;
                CFG_SMALL_LIMIT: cfg_reg.small_limit <= cfg_data[15:0];
            endcase
        end
    end

    ffpa_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .y      (alu_y),
        .borrow (alu_borrow)
    );

    ffpa_bitmap u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (bm_req),
        .rd_data (bm_rd_data),
        .busy    (bm_busy)
    );

    ffpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .bm_busy    (bm_busy),
        .bm_rd_data (bm_rd_data),
        .bm_req     (bm_req),
        .alu_op     (alu_op),
        .alu_a      (alu_a),
        .alu_b      (alu_b),
        .alu_y      (alu_y),
        .alu_borrow (alu_borrow)
    );

endmodule

// ===== rtl/ffpa_alu.sv =====
module ffpa_alu (
    input  ffpa_pkg::alu_op_t           op,
    input  logic [ffpa_pkg::WIDE_W-1:0] a,
    input  logic [ffpa_pkg::WIDE_W-1:0] b,
    output logic [ffpa_pkg::WIDE_W-1:0] y,
    output logic                        borrow
);
    import ffpa_pkg::*;

    logic [WIDE_W:0] sum;

    always_comb
    begin
        unique case (op)
            ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            ALU_SUB: sum = {1'b0, a} - {1'b0, b};
        endcase
    end

    assign y      = sum[WIDE_W-1:0];
    assign borrow = (op == ALU_SUB) && sum[WIDE_W];

endmodule

// ===== rtl/ffpa_bitmap.sv =====
module ffpa_bitmap (
    input  logic              clk,
    input  logic              rst_n,
    input  ffpa_pkg::bm_req_t req,
    output logic              rd_data,
    output logic              busy
);
    import ffpa_pkg::*;

    logic             mem [NUM_PAGES];
    logic [IDX_W-1:0] clr_ptr_reg;
    logic             busy_reg;
    logic             rd_data_reg;

    // sweep clears one page per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (clr_ptr_reg == IDX_W'(NUM_PAGES - 1))
                busy_reg <= 1'b0;
            clr_ptr_reg <= clr_ptr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_ptr_reg] <= 1'b0;
        else if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== rtl/ffpa_ctrl.sv =====
module ffpa_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ffpa_pkg::cfg_regs_t         cfg,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  ffpa_pkg::req_item_t         req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output ffpa_pkg::rsp_item_t         rsp,
    input  logic                        bm_busy,
    input  logic                        bm_rd_data,
    output ffpa_pkg::bm_req_t           bm_req,
    output ffpa_pkg::alu_op_t           alu_op,
    output logic [ffpa_pkg::WIDE_W-1:0] alu_a,
    output logic [ffpa_pkg::WIDE_W-1:0] alu_b,
    input  logic [ffpa_pkg::WIDE_W-1:0] alu_y,
    input  logic                        alu_borrow
);
    import ffpa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE,
        S_PAGES,
        S_ANEED,
        S_ACHECK,
        S_SCAN,
        S_MARK,
        S_FRANGE,
        S_FDIFF,
        S_FREAD,
        S_FCLR,
        S_DONE
    } state_t;

    state_t    state_reg, state_next;
    logic      out_valid_reg, out_valid_next;
    rsp_item_t out_item_reg, out_item_next;

    req_item_t          item_reg, item_next;
    logic [WIDE_W-1:0]  base_reg, base_next;
    logic [WIDE_W-1:0]  acc_reg, acc_next;
    logic [PG_W-1:0]    total_reg, total_next;
    logic [PG_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]   need_reg, need_next;
    logic [CNT_W-1:0]   tally_reg, tally_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   first_reg, first_next;
    rsp_item_t          res_reg, res_next;

    logic [CNT_W-1:0] rl_mem [NUM_PAGES];
    logic [CNT_W-1:0] rl_rd_reg;
    logic             rl_we;

    logic [ADDR_W-1:0] aligned;
    logic [WIDE_W-1:0] need_q;
    logic [WIDE_W-1:0] pages_q;
    logic [PG_W-1:0]   ptr_plus;
    logic [CNT_W-1:0]  run_new;
    logic [IDX_W-1:0]  first_new;
    bm_req_t           bm_req_c;

    function automatic rsp_item_t err_rsp(input logic [2:0] st);
        rsp_item_t r;
        r.status        = st;
        r.address       = '0;
        r.pages_changed = '0;
        return r;
    endfunction

    assign aligned  = item_reg.release_address & ~ADDR_W'(PAGE_BYTES - 1);
    assign need_q   = acc_reg >> PAGE_SHIFT;
    assign pages_q  = alu_y >> PAGE_SHIFT;
    assign ptr_plus = ptr_reg + PG_W'(1);
    assign run_new  = bm_rd_data ? '0 : tally_reg + CNT_W'(1);
    assign first_new = (!bm_rd_data && tally_reg == '0) ? ptr_reg[IDX_W-1:0] : first_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        item_next      = item_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        ptr_next       = ptr_reg;
        need_next      = need_reg;
        tally_next     = tally_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        res_next       = res_reg;
        rl_we          = 1'b0;
        alu_op         = ALU_ADD;
        alu_a          = '0;
        alu_b          = '0;
        bm_req_c.rd_addr = ptr_reg[IDX_W-1:0];
        bm_req_c.wr_en   = 1'b0;
        bm_req_c.wr_addr = ptr_reg[IDX_W-1:0];
        bm_req_c.wr_data = 1'b0;

        if (out_valid_reg && rsp_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    item_next  = req;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                alu_a      = {1'b0, cfg.heap_limit};
                alu_b      = WIDE_W'(PAGE_BYTES);
                base_next  = alu_y;
                state_next = S_PAGES;
            end
            S_PAGES:
            begin
                alu_op = ALU_SUB;
                alu_a  = {1'b0, cfg.heap_end};
                alu_b  = base_reg;
                priority if (alu_borrow)
                    total_next = '0;
                else if (pages_q > WIDE_W'(NUM_PAGES))
                    total_next = PG_W'(NUM_PAGES);
                else
                    total_next = pages_q[PG_W-1:0];
                state_next = (item_reg.cmd == CMD_FREE) ? S_FRANGE : S_ANEED;
            end
            S_ANEED:
            begin
                alu_a      = {1'b0, item_reg.request_bytes};
                alu_b      = WIDE_W'(PAGE_BYTES - 1);
                acc_next   = alu_y;
                state_next = S_ACHECK;
            end
            S_ACHECK:
            begin
                priority if (item_reg.request_bytes == '0)
                begin
                    res_next   = err_rsp(ST_ZERO);
                    state_next = S_DONE;
                end
                else if (item_reg.request_bytes <= {16'b0, cfg.small_limit})
                begin
                    res_next   = err_rsp(ST_SMALL);
                    state_next = S_DONE;
                end
                else if (need_q > WIDE_W'(total_reg) || need_q > WIDE_W'(RUN_MAX))
                begin
                    res_next   = err_rsp(ST_NOSPACE);
                    state_next = S_DONE;
                end
                else
                begin
                    need_next        = need_q[CNT_W-1:0];
                    tally_next       = '0;
                    ptr_next         = '0;
                    bm_req_c.rd_addr = '0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (run_new == need_reg)
                begin
                    rl_we      = 1'b1;
                    first_next = first_new;
                    ptr_next   = PG_W'(first_new);
                    cnt_next   = need_reg;
                    state_next = S_MARK;
                end
                else if (ptr_plus == total_reg)
                begin
                    res_next   = err_rsp(ST_NOSPACE);
                    state_next = S_DONE;
                end
                else
                begin
                    first_next       = first_new;
                    tally_next       = run_new;
                    ptr_next         = ptr_plus;
                    bm_req_c.rd_addr = ptr_plus[IDX_W-1:0];
                end
            end
            S_MARK:
            begin
                bm_req_c.wr_en   = 1'b1;
                bm_req_c.wr_data = 1'b1;
                alu_a    = base_reg;
                alu_b    = WIDE_W'({first_reg, {PAGE_SHIFT{1'b0}}});
                ptr_next = ptr_plus;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    res_next.status        = ST_OK;
                    res_next.address       = alu_y[ADDR_W-1:0];
                    res_next.pages_changed = need_reg;
                    state_next             = S_DONE;
                end
            end
            S_FRANGE:
            begin
                priority if (item_reg.release_address < cfg.heap_start ||
                             item_reg.release_address > cfg.heap_end)
                begin
                    res_next   = err_rsp(ST_INVALID);
                    state_next = S_DONE;
                end
                else if (item_reg.release_address < cfg.heap_limit)
                begin
                    res_next   = err_rsp(ST_BLOCK);
                    state_next = S_DONE;
                end
                else
                    state_next = S_FDIFF;
            end
            S_FDIFF:
            begin
                alu_op = ALU_SUB;
                alu_a  = {1'b0, aligned};
                alu_b  = base_reg;
                priority if (alu_borrow || pages_q >= WIDE_W'(total_reg))
                begin
                    res_next   = err_rsp(ST_INVALID);
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next         = PG_W'(pages_q[IDX_W-1:0]);
                    bm_req_c.rd_addr = pages_q[IDX_W-1:0];
                    state_next       = S_FREAD;
                end
            end
            S_FREAD:
            begin
                if (!bm_rd_data)
                begin
                    res_next   = err_rsp(ST_INVALID);
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = rl_rd_reg;
                    tally_next = '0;
                    state_next = S_FCLR;
                end
            end
            S_FCLR:
            begin
                if (tally_reg == cnt_reg || ptr_reg == PG_W'(NUM_PAGES))
                begin
                    res_next.status        = ST_OK;
                    res_next.address       = '0;
                    res_next.pages_changed = tally_reg;
                    state_next             = S_DONE;
                end
                else
                begin
                    bm_req_c.wr_en = 1'b1;
                    ptr_next       = ptr_plus;
                    tally_next     = tally_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_item_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        base_reg  <= base_next;
        acc_reg   <= acc_next;
        total_reg <= total_next;
        ptr_reg   <= ptr_next;
        need_reg  <= need_next;
        tally_reg <= tally_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        res_reg   <= res_next;
    end

    // run length per allocated run, kept at its first page
    always_ff @(posedge clk)
    begin
        if (rl_we)
            rl_mem[first_new] <= need_reg;
        rl_rd_reg <= rl_mem[bm_req_c.rd_addr];
    end

    assign bm_req    = bm_req_c;
    assign req_ready = (state_reg == S_IDLE) && !bm_busy;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

endmodule

// ===== rtl/ffpa_checker.sv =====
`include "first_fit_page_allocator_assert.svh"

module ffpa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input ffpa_pkg::req_item_t req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input ffpa_pkg::rsp_item_t rsp
);
    import ffpa_pkg::*;

    `FFPA_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready, rsp, "rsp item dropped or changed")
    `FFPA_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "ready right after accept")
    `FFPA_ASSERT(a_err_clean, (rsp_valid && rsp.status != ST_OK) |-> (rsp.address == '0 && rsp.pages_changed == '0), "error item carries data")
    `FFPA_ASSERT(a_alloc_pages, (rsp_valid && rsp.status == ST_OK && rsp.address != '0) |-> (rsp.pages_changed != '0), "allocation with no pages")

endmodule

bind first_fit_page_allocator ffpa_checker u_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import ffpa_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_item_t             req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_item_t             rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ADDR_W-1:0]     cfg_data  = '0;

    first_fit_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // shadow copy of the allocator
    logic [31:0] cfg_start = HEAP_START_RST;
    logic [31:0] cfg_limit = HEAP_LIMIT_RST;
    logic [31:0] cfg_end   = HEAP_END_RST;
    logic [15:0] cfg_small = SMALL_LIMIT_RST;
    bit          page_busy [NUM_PAGES];
    bit [10:0]   run_pages [NUM_PAGES];
    bit          run_set   [NUM_PAGES];
    int          live_runs [$];

    rsp_item_t   replies_due [$];
    int          err_count = 0;
    int          n_results = 0;
    bit          idle_on = 1'b1;

    typedef struct {
        logic        cmd;
        logic [31:0] arg;
        bit          given;
        logic [2:0]  st;
        logic [31:0] addr;
        logic [10:0] pages;
    } step_t;

    localparam int N_STEPS = 26;

    step_t steps [N_STEPS] = '{
        '{CMD_ALLOC, 32'h0000_0000, 1'b1, ST_ZERO,    32'h0000_0000, 11'd0},
        '{CMD_ALLOC, 32'h0000_0800, 1'b1, ST_SMALL,   32'h0000_0000, 11'd0},
        '{CMD_ALLOC, 32'h0000_0801, 1'b1, ST_OK,      32'h8200_1000, 11'd1},
        '{CMD_ALLOC, 32'hFFFF_FFFF, 1'b1, ST_NOSPACE, 32'h0000_0000, 11'd0},
        '{CMD_ALLOC, 32'h0040_0000, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_ALLOC, 32'h0000_2001, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h7FFF_FFFF, 1'b1, ST_INVALID, 32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'hA000_0001, 1'b1, ST_INVALID, 32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8000_0000, 1'b1, ST_BLOCK,   32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8200_0000, 1'b1, ST_INVALID, 32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8200_0FFF, 1'b1, ST_INVALID, 32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'hA000_0000, 1'b1, ST_INVALID, 32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8240_1000, 1'b1, ST_INVALID, 32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8200_5000, 1'b1, ST_INVALID, 32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8200_2ABC, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8200_2000, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_ALLOC, 32'h0000_1001, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_ALLOC, 32'h0000_0801, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8200_4000, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8200_2000, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_ALLOC, 32'h0000_3000, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        // stale count left on a page inside a run
        '{CMD_FREE,  32'h8200_4010, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8200_1000, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8200_2000, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_ALLOC, 32'h0040_0000, 1'b0, ST_OK,      32'h0000_0000, 11'd0},
        '{CMD_FREE,  32'h8200_1FFF, 1'b0, ST_OK,      32'h0000_0000, 11'd0}
    };

    function automatic longint unsigned region_base();
        longint unsigned b;
        b = cfg_limit;
        return b + PAGE_BYTES;
    endfunction

    function automatic int region_pages();
        longint unsigned b;
        longint unsigned n;
        b = region_base();
        if (b >= cfg_end)
            return 0;
        n = (cfg_end - b) / PAGE_BYTES;
        return (n > NUM_PAGES) ? NUM_PAGES : int'(n);
    endfunction

    // page whose run count a free would read, or -1 with the error status
    function automatic int free_target(input logic [31:0] addr, output logic [2:0] st);
        longint unsigned a;
        longint unsigned aligned;
        longint unsigned base;
        longint unsigned idx;
        a = addr;
        base = region_base();
        st = ST_INVALID;
        if (a < cfg_start || a > cfg_end)
            return -1;
        if (a < cfg_limit)
        begin
            st = ST_BLOCK;
            return -1;
        end
        aligned = a - (a % PAGE_BYTES);
        if (aligned < base)
            return -1;
        idx = (aligned - base) / PAGE_BYTES;
        if (idx >= region_pages() || !page_busy[idx])
            return -1;
        st = ST_OK;
        return int'(idx);
    endfunction

    function automatic rsp_item_t allocator_reply(input req_item_t it);
        rsp_item_t       r;
        longint unsigned bytes;
        longint unsigned need;
        longint unsigned a;
        logic [2:0]      st;
        int              total;
        int              run;
        int              first;
        int              idx;
        int              cleared;
        r = '0;
        r.status = ST_OK;
        if (it.cmd == CMD_ALLOC)
        begin
            bytes = it.request_bytes;
            if (bytes == 0)
                r.status = ST_ZERO;
            else if (bytes <= cfg_small)
                r.status = ST_SMALL;
            else
            begin
                need = (bytes + PAGE_BYTES - 1) / PAGE_BYTES;
                total = region_pages();
                run = 0;
                first = 0;
                for (int i = 0; i < total && run < need; i++)
                begin
                    if (!page_busy[i])
                    begin
                        if (run == 0)
                            first = i;
                        run++;
                    end
                    else
                        run = 0;
                end
                if (run != need)
                    r.status = ST_NOSPACE;
                else
                begin
                    run_pages[first] = need[10:0];
                    run_set[first] = 1'b1;
                    for (int i = first; i < first + run; i++)
                        page_busy[i] = 1'b1;
                    live_runs.push_back(first);
                    a = region_base() + first * PAGE_BYTES;
                    r.address = a[31:0];
                    r.pages_changed = need[10:0];
                end
            end
        end
        else
        begin
            idx = free_target(it.release_address, st);
            r.status = st;
            if (idx >= 0)
            begin
                cleared = 0;
                for (int i = idx; i < idx + run_pages[idx] && i < NUM_PAGES; i++)
                begin
                    page_busy[i] = 1'b0;
                    cleared++;
                end
                r.pages_changed = cleared[10:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 40)
            $display("result %0d: %s: got %0h, expected %0h", n_results, what, got, want);
    endtask

    task automatic check_reply(input rsp_item_t got);
        rsp_item_t want;
        n_results++;
        if (replies_due.size() == 0)
        begin
            report_mismatch("no result pending", 32'(got.status), 32'd0);
            return;
        end
        want = replies_due.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.address !== want.address)
            report_mismatch("address", got.address, want.address);
        if (got.pages_changed !== want.pages_changed)
            report_mismatch("pages_changed", 32'(got.pages_changed),
                            32'(want.pages_changed));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                check_reply(rsp);
            end
            rsp_ready <= !(idle_on && $urandom_range(99) < 7);
        end
    end

    task automatic idle_sender();
        while (idle_on && $urandom_range(99) < 7)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic issue(input req_item_t it, input bit given, input rsp_item_t want);
        rsp_item_t r;
        req_valid <= 1'b1;
        req <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        r = allocator_reply(it);
        replies_due.push_back(given ? want : r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_HEAP_START:  cfg_start = value;
            CFG_HEAP_LIMIT:  cfg_limit = value;
            CFG_HEAP_END:    cfg_end = value;
            CFG_SMALL_LIMIT: cfg_small = value[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic make_random(output req_item_t it);
        int              k;
        int              pg;
        int              j;
        int              idx;
        int              total;
        logic [2:0]      st;
        longint unsigned base;
        k = $urandom_range(99);
        base = region_base();
        total = region_pages();
        it.cmd = CMD_ALLOC;
        it.request_bytes = $urandom;
        it.release_address = $urandom;
        if (k < (live_runs.size() > 10 ? 35 : 50))
        begin
            pg = ($urandom_range(19) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 6);
            it.request_bytes = cfg_small + $urandom_range(1, pg * PAGE_BYTES);
        end
        else if (k < 82 && live_runs.size() != 0)
        begin
            j = $urandom_range(live_runs.size() - 1);
            it.cmd = CMD_FREE;
            it.release_address = 32'(base + live_runs[j] * PAGE_BYTES
                                     + $urandom_range(PAGE_BYTES - 1));
            live_runs.delete(j);
        end
        else
        begin
            case ($urandom_range(5))
                0: ;
                1: it.request_bytes = $urandom_range(cfg_small);
                2: it.cmd = CMD_FREE;
                3:
                begin
                    it.cmd = CMD_FREE;
                    it.release_address = 32'(base
                        + $urandom_range(total * PAGE_BYTES + PAGE_BYTES - 1));
                end
                4:
                begin
                    it.cmd = CMD_FREE;
                    case ($urandom_range(7))
                        0: it.release_address = cfg_start - 1;
                        1: it.release_address = cfg_start;
                        2: it.release_address = cfg_limit - 1;
                        3: it.release_address = cfg_limit;
                        4: it.release_address = cfg_end;
                        5: it.release_address = cfg_end + 1;
                        6: it.release_address = 32'(base - 1);
                        default: it.release_address = 32'(base);
                    endcase
                end
                default:
                    it.request_bytes = $urandom_range(1000, 2100) * PAGE_BYTES
                                       - $urandom_range(PAGE_BYTES - 1);
            endcase
        end
        // a count that was never written must not be read back
        if (it.cmd == CMD_FREE)
        begin
            idx = free_target(it.release_address, st);
            if (idx >= 0 && !run_set[idx])
            begin
                it.cmd = CMD_ALLOC;
                it.request_bytes = 0;
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] s, input logic [31:0] l, input logic [31:0] e,
                             input logic [15:0] sm, input int count, input bit quiet);
        req_item_t it;
        drain();
        write_reg(CFG_HEAP_START, s);
        write_reg(CFG_HEAP_LIMIT, l);
        write_reg(CFG_HEAP_END, e);
        write_reg(CFG_SMALL_LIMIT, {16'd0, sm});
        cfg_valid <= 1'b0;
        idle_on <= !quiet;
        for (int n = 0; n < count; n++)
        begin
            idle_sender();
            make_random(it);
            issue(it, 1'b0, '0);
        end
    endtask

    initial
    begin
        #200_000_000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        req_item_t it;
        rsp_item_t want;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < N_STEPS; n++)
        begin
            idle_sender();
            it.cmd = steps[n].cmd;
            it.request_bytes = (steps[n].cmd == CMD_ALLOC) ? steps[n].arg : $urandom;
            it.release_address = (steps[n].cmd == CMD_FREE) ? steps[n].arg : $urandom;
            want.status = steps[n].st;
            want.address = steps[n].addr;
            want.pages_changed = steps[n].pages;
            issue(it, steps[n].given, want);
        end

        // 40-page region with a ragged end, every nonzero size goes to pages
        run_phase(32'h0FFF_0000, 32'h1000_0000, 32'h1002_9800, 16'h0000, 150, 1'b0);
        // region lies past the top of the address space
        run_phase(32'hFFFF_FFFF, 32'hFFFF_F000, 32'hFFFF_FFFF, 16'hFFFF, 25, 1'b0);
        run_phase(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0001, 15, 1'b0);
        run_phase(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 16'd12345, 150, 1'b1);
        run_phase(HEAP_START_RST, HEAP_LIMIT_RST, HEAP_END_RST, SMALL_LIMIT_RST, 215, 1'b0);

        drain();
        repeat (64) @(posedge clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
